>>> rtl/core/lpmd_pkg.sv
// Shared types, constants and helpers for the length-prefixed message deframer.
`timescale 1ns / 1ps

package lpmd_pkg;

   localparam int HEADER_BYTES = 9;
   localparam int LENGTH_BITS  = 32;
   localparam int LEN_W        = 32;
   localparam int REMAIN_W     = 33;
   localparam int HCNT_W       = 4;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [LEN_W-1:0]    len_type;
   typedef logic [REMAIN_W-1:0] remain_type;
   typedef logic [HCNT_W-1:0]   hcnt_type;

   localparam len_type  MAX_PART_RESET = len_type'(1048576);
   localparam hcnt_type HDR_VERSION    = hcnt_type'(0);
   localparam hcnt_type HDR_CMD_LAST   = hcnt_type'(4);
   localparam hcnt_type HDR_LAST       = hcnt_type'(HEADER_BYTES - 1);

   typedef enum logic [KIND_W-1:0] {
      KIND_HEADER  = 2'd0,
      KIND_COMMAND = 2'd1,
      KIND_VALUE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic     valid;
      byte_type rx_byte;
   } stage_type;

   typedef struct packed {
      logic       valid;
      byte_type   data_byte;
      kind_type   byte_kind;
      logic       message_end;
      logic       header_error;
      byte_type   version_tag;
      len_type    command_length;
      len_type    value_length;
      remain_type bytes_remaining;
   } result_type;

   function automatic logic length_too_big(input len_type len, input len_type limit);
      logic too_wide;
      too_wide = (LENGTH_BITS < LEN_W) ? ((len >> LENGTH_BITS) != '0) : 1'b0;
      return (len > limit) || too_wide;
   endfunction

endpackage

>>> rtl/core/lpmd_req_if.sv
// Request channel interface: one received byte per request.
`timescale 1ns / 1ps

interface lpmd_req_if;
   logic                  valid;
   logic                  ready;
   lpmd_pkg::byte_type    rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/lpmd_rsp_if.sv
// Response channel interface: one tagged byte per response.
`timescale 1ns / 1ps

interface lpmd_rsp_if;
   logic                         valid;
   logic                         ready;
   lpmd_pkg::byte_type           data_byte;
   logic [lpmd_pkg::KIND_W-1:0]  byte_kind;
   logic                         message_end;
   logic                         header_error;
   lpmd_pkg::byte_type           version_tag;
   lpmd_pkg::len_type            command_length;
   lpmd_pkg::len_type            value_length;
   lpmd_pkg::remain_type         bytes_remaining;

   modport source (
      output valid, output data_byte, output byte_kind, output message_end,
      output header_error, output version_tag, output command_length,
      output value_length, output bytes_remaining, input ready
   );
   modport sink (
      input valid, input data_byte, input byte_kind, input message_end,
      input header_error, input version_tag, input command_length,
      input value_length, input bytes_remaining, output ready
   );
endinterface

>>> rtl/core/length_prefixed_message_deframer_top.sv
// Top level of the length-prefixed message deframer.
//
//   channel      direction  contents
//   req_channel  in         rx_byte, one stream byte per request
//   rsp_channel  out        byte with region, end/error flags, header, remainder
//   csr_*        in         max_part_length write, no read-back
//
// One request in and one response out per cycle when neither side stalls.
// Each byte passes the input register, then the deframing logic into the
// response register; the header length check and body countdown settle there.
// Reset is synchronous; it clears both stages and returns to header search.
// A response stall backs up through the input register to req_channel.ready.
`timescale 1ns / 1ps

module length_prefixed_message_deframer_top (
   input  logic              clock,
   input  logic              reset,
   lpmd_req_if.sink          req_channel,
   lpmd_rsp_if.source        rsp_channel,
   input  logic              csr_write_enable,
   input  lpmd_pkg::len_type csr_write_data
);

   lpmd_pkg::stage_type  stage;
   lpmd_pkg::result_type result;
   logic                 advance;

   lpmd_in_stage u_in_stage (
      .clock   (clock),
      .reset   (reset),
      .req     (req_channel),
      .advance (advance),
      .stage   (stage)
   );

   lpmd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .advance          (advance),
      .result           (result)
   );

   lpmd_out_stage u_out_stage (
      .clock   (clock),
      .reset   (reset),
      .result  (result),
      .advance (advance),
      .rsp     (rsp_channel)
   );

endmodule

>>> rtl/core/lpmd_in_stage.sv
// Input register stage: captures one request byte and holds it until processed.
`timescale 1ns / 1ps

module lpmd_in_stage (
   input  logic                clock,
   input  logic                reset,
   lpmd_req_if.sink            req,
   input  logic                advance,
   output lpmd_pkg::stage_type stage
);

   logic               valid_ff, valid_in;
   lpmd_pkg::byte_type byte_ff, byte_in;
   logic               take;

   assign req.ready = !valid_ff || advance;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req.rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign stage.valid   = valid_ff;
   assign stage.rx_byte = byte_ff;

endmodule

>>> rtl/core/lpmd_core.sv
// Deframing state: header assembly, length check, body counting and byte tagging.
`timescale 1ns / 1ps

module lpmd_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  lpmd_pkg::len_type    csr_write_data,
   input  lpmd_pkg::stage_type  stage,
   input  logic                 advance,
   output lpmd_pkg::result_type result
);

   logic                 in_body_ff, in_body_in;
   lpmd_pkg::hcnt_type   hcnt_ff, hcnt_in;
   lpmd_pkg::byte_type   ver_ff, ver_in;
   lpmd_pkg::len_type    cmd_ff, cmd_in;
   lpmd_pkg::len_type    val_ff, val_in;
   lpmd_pkg::remain_type remain_ff, remain_in;
   lpmd_pkg::len_type    max_ff, max_in;
   lpmd_pkg::remain_type total;
   logic                 too_big;

   always_comb begin
      in_body_in = in_body_ff;
      hcnt_in    = hcnt_ff;
      ver_in     = ver_ff;
      cmd_in     = cmd_ff;
      val_in     = val_ff;
      remain_in  = remain_ff;
      max_in     = csr_write_enable ? csr_write_data : max_ff;

      result                 = '0;
      result.valid           = stage.valid;
      result.data_byte       = stage.rx_byte;
      result.byte_kind       = lpmd_pkg::KIND_HEADER;

      total   = '0;
      too_big = 1'b0;

      if (in_body_ff) begin
         result.byte_kind      = (remain_ff > lpmd_pkg::remain_type'(val_ff))
                                 ? lpmd_pkg::KIND_COMMAND : lpmd_pkg::KIND_VALUE;
         result.version_tag    = ver_ff;
         result.command_length = cmd_ff;
         result.value_length   = val_ff;
         if (remain_ff == lpmd_pkg::remain_type'(1)) begin
            result.message_end = 1'b1;
            in_body_in         = 1'b0;
            hcnt_in            = '0;
            remain_in          = '0;
         end else begin
            result.bytes_remaining = remain_ff - lpmd_pkg::remain_type'(1);
            remain_in              = remain_ff - lpmd_pkg::remain_type'(1);
         end
      end else begin
         if (hcnt_ff == lpmd_pkg::HDR_VERSION) begin
            ver_in = stage.rx_byte;
         end else if (hcnt_ff <= lpmd_pkg::HDR_CMD_LAST) begin
            cmd_in = {cmd_ff[lpmd_pkg::LEN_W-lpmd_pkg::BYTE_W-1:0], stage.rx_byte};
         end else begin
            val_in = {val_ff[lpmd_pkg::LEN_W-lpmd_pkg::BYTE_W-1:0], stage.rx_byte};
         end
         total   = lpmd_pkg::remain_type'(cmd_in) + lpmd_pkg::remain_type'(val_in);
         too_big = lpmd_pkg::length_too_big(cmd_in, max_ff)
                   || lpmd_pkg::length_too_big(val_in, max_ff);
         if (hcnt_ff >= lpmd_pkg::HDR_LAST) begin
            result.version_tag    = ver_in;
            result.command_length = cmd_in;
            result.value_length   = val_in;
            hcnt_in               = '0;
            if (too_big) begin
               result.header_error = 1'b1;
            end else if (total == '0) begin
               result.message_end = 1'b1;
            end else begin
               in_body_in             = 1'b1;
               remain_in              = total;
               result.bytes_remaining = total;
            end
         end else begin
            hcnt_in                = hcnt_ff + lpmd_pkg::hcnt_type'(1);
            result.bytes_remaining = lpmd_pkg::remain_type'(lpmd_pkg::HDR_LAST - hcnt_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_body_ff <= 1'b0;
         hcnt_ff    <= '0;
         ver_ff     <= '0;
         cmd_ff     <= '0;
         val_ff     <= '0;
         remain_ff  <= '0;
         max_ff     <= lpmd_pkg::MAX_PART_RESET;
      end else begin
         max_ff <= max_in;
         if (advance) begin
            in_body_ff <= in_body_in;
            hcnt_ff    <= hcnt_in;
            ver_ff     <= ver_in;
            cmd_ff     <= cmd_in;
            val_ff     <= val_in;
            remain_ff  <= remain_in;
         end
      end
   end

   a_end_err_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(result.valid && result.message_end && result.header_error))
      else $error("message end and header error on one byte");

   a_body_header_idle: assert property (@(posedge clock) disable iff (reset)
      in_body_ff |-> (hcnt_ff == '0) && (remain_ff != '0))
      else $error("body state with header count or empty remainder");

   a_body_countdown: assert property (@(posedge clock) disable iff (reset)
      advance && in_body_ff && (remain_ff != lpmd_pkg::remain_type'(1))
      |=> in_body_ff && (remain_ff == $past(remain_ff) - lpmd_pkg::remain_type'(1)))
      else $error("body countdown slipped");

   a_end_leaves_body: assert property (@(posedge clock) disable iff (reset)
      advance && (result.message_end || result.header_error) |=> !in_body_ff)
      else $error("still in body after message end or header error");

endmodule

>>> rtl/core/lpmd_out_stage.sv
// Response register stage: holds one tagged byte until the sink takes it.
`timescale 1ns / 1ps

module lpmd_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  lpmd_pkg::result_type result,
   output logic                 advance,
   lpmd_rsp_if.source           rsp
);

   logic                 valid_ff, valid_in;
   lpmd_pkg::result_type data_ff, data_in;

   assign advance = result.valid && (!valid_ff || rsp.ready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (advance) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp.valid           = valid_ff;
   assign rsp.data_byte       = data_ff.data_byte;
   assign rsp.byte_kind       = data_ff.byte_kind;
   assign rsp.message_end     = data_ff.message_end;
   assign rsp.header_error    = data_ff.header_error;
   assign rsp.version_tag     = data_ff.version_tag;
   assign rsp.command_length  = data_ff.command_length;
   assign rsp.value_length    = data_ff.value_length;
   assign rsp.bytes_remaining = data_ff.bytes_remaining;

endmodule

>>> bench/length_prefixed_message_deframer_top_tb.sv
// Testbench for the length-prefixed message deframer: byte stream in, tagged bytes out.
`timescale 1ns / 1ps

module length_prefixed_message_deframer_top_tb;

   localparam int CYCLE_LIMIT = 250000;
   localparam int REPORT_MAX  = 10;

   typedef struct packed {
      lpmd_pkg::byte_type          data;
      logic [lpmd_pkg::KIND_W-1:0] kind;
      logic                        msg_end;
      logic                        hdr_err;
      lpmd_pkg::byte_type          ver;
      lpmd_pkg::len_type           clen;
      lpmd_pkg::len_type           vlen;
      lpmd_pkg::remain_type        remain;
   } frame_byte_type;

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   lpmd_pkg::len_type csr_write_data;

   lpmd_req_if req_ch ();
   lpmd_rsp_if rsp_ch ();

   length_prefixed_message_deframer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_channel      (req_ch),
      .rsp_channel      (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   frame_byte_type pending_bytes[$];
   frame_byte_type got_byte;
   frame_byte_type want_byte;

   lpmd_pkg::hcnt_type   hdr_pos    = '0;
   logic                 in_msg     = 1'b0;
   lpmd_pkg::byte_type   cur_ver    = '0;
   lpmd_pkg::len_type    cur_clen   = '0;
   lpmd_pkg::len_type    cur_vlen   = '0;
   lpmd_pkg::remain_type body_pos   = '0;
   lpmd_pkg::len_type    part_limit = lpmd_pkg::MAX_PART_RESET;

   int   burst_left  = 0;
   bit   steady      = 1'b0;
   logic [7:0] stall_mask = 8'hFF;
   int   mask_age    = 0;
   int   cycle_count = 0;
   int   sent_count  = 0;
   int   resp_count  = 0;
   int   fail_count  = 0;
   int   end_seen    = 0;
   int   err_seen    = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic frame_byte_type deframe_byte(input lpmd_pkg::byte_type b);
      frame_byte_type       r;
      lpmd_pkg::remain_type total;
      r = '0;
      r.data = b;
      if (in_msg) begin
         total = {1'b0, cur_clen} + {1'b0, cur_vlen};
         r.kind = (body_pos < {1'b0, cur_clen}) ? lpmd_pkg::KIND_COMMAND
                                                : lpmd_pkg::KIND_VALUE;
         body_pos = body_pos + 1'b1;
         r.ver  = cur_ver;
         r.clen = cur_clen;
         r.vlen = cur_vlen;
         if (body_pos >= total) begin
            r.msg_end = 1'b1;
            in_msg    = 1'b0;
            hdr_pos   = '0;
            body_pos  = '0;
         end else begin
            r.remain = total - body_pos;
         end
      end else begin
         r.kind = lpmd_pkg::KIND_HEADER;
         if (hdr_pos == lpmd_pkg::HDR_VERSION) cur_ver = b;
         else if (hdr_pos <= lpmd_pkg::HDR_CMD_LAST)
            cur_clen = {cur_clen[lpmd_pkg::LEN_W-lpmd_pkg::BYTE_W-1:0], b};
         else cur_vlen = {cur_vlen[lpmd_pkg::LEN_W-lpmd_pkg::BYTE_W-1:0], b};
         if (hdr_pos == lpmd_pkg::HDR_LAST) begin
            r.ver    = cur_ver;
            r.clen   = cur_clen;
            r.vlen   = cur_vlen;
            hdr_pos  = '0;
            body_pos = '0;
            if (cur_clen > part_limit || cur_vlen > part_limit) begin
               r.hdr_err = 1'b1;
            end else if (cur_clen == '0 && cur_vlen == '0) begin
               r.msg_end = 1'b1;
            end else begin
               in_msg   = 1'b1;
               r.remain = {1'b0, cur_clen} + {1'b0, cur_vlen};
            end
         end else begin
            hdr_pos  = hdr_pos + 1'b1;
            r.remain = lpmd_pkg::remain_type'(lpmd_pkg::HEADER_BYTES)
                       - lpmd_pkg::remain_type'(hdr_pos);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got_byte = '{rsp_ch.data_byte, rsp_ch.byte_kind, rsp_ch.message_end,
                         rsp_ch.header_error, rsp_ch.version_tag, rsp_ch.command_length,
                         rsp_ch.value_length, rsp_ch.bytes_remaining};
            if (got_byte.msg_end === 1'b1) end_seen++;
            if (got_byte.hdr_err === 1'b1) err_seen++;
            if (pending_bytes.size() == 0) begin
               fail_count++;
               if (fail_count <= REPORT_MAX)
                  $display("response %0d arrived with no request outstanding: data=%02h",
                           resp_count, got_byte.data);
            end else begin
               want_byte = pending_bytes.pop_front();
               if (got_byte !== want_byte) begin
                  fail_count++;
                  if (fail_count <= REPORT_MAX) begin
                     $display("response %0d expected data=%02h kind=%0d end=%b err=%b ",
                              resp_count, want_byte.data, want_byte.kind, want_byte.msg_end,
                              want_byte.hdr_err,
                              "ver=%02h clen=%08h vlen=%08h rem=%09h",
                              want_byte.ver, want_byte.clen,
                              want_byte.vlen, want_byte.remain);
                     $display("response %0d actual   data=%02h kind=%0d end=%b err=%b ",
                              resp_count, got_byte.data, got_byte.kind, got_byte.msg_end,
                              got_byte.hdr_err,
                              "ver=%02h clen=%08h vlen=%08h rem=%09h",
                              got_byte.ver, got_byte.clen,
                              got_byte.vlen, got_byte.remain);
                  end
               end
            end
            resp_count++;
         end
         if (req_ch.valid && req_ch.ready)
            pending_bytes.push_back(deframe_byte(req_ch.rx_byte));
      end
   end

   always @(posedge clock) begin
      if (steady) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= stall_mask[0];
      end
      if (mask_age == 47) begin
         stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
         mask_age   <= 0;
      end else begin
         stall_mask <= {stall_mask[0], stall_mask[7:1]};
         mask_age   <= mask_age + 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d requests still outstanding",
                  cycle_count, pending_bytes.size());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_byte(input lpmd_pkg::byte_type b);
      int gap;
      if (!steady && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
      sent_count++;
   endtask

   task automatic drain_requests();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   task automatic write_part_limit(input lpmd_pkg::len_type limit);
      drain_requests();
      csr_write_enable <= 1'b1;
      csr_write_data   <= limit;
      part_limit = limit;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_header(input lpmd_pkg::byte_type ver, input lpmd_pkg::len_type clen,
                              input lpmd_pkg::len_type vlen);
      send_byte(ver);
      for (int i = 3; i >= 0; i--) send_byte(clen[8*i +: 8]);
      for (int i = 3; i >= 0; i--) send_byte(vlen[8*i +: 8]);
   endtask

   task automatic send_message(input lpmd_pkg::byte_type ver, input lpmd_pkg::len_type clen,
                               input lpmd_pkg::len_type vlen, input int cut);
      lpmd_pkg::remain_type body_len;
      send_header(ver, clen, vlen);
      if (clen <= part_limit && vlen <= part_limit) begin
         body_len = {1'b0, clen} + {1'b0, vlen};
         if (cut > 0 && cut < body_len) body_len = body_len - lpmd_pkg::remain_type'(cut);
         repeat (body_len) send_byte(8'($urandom));
      end
   endtask

   function automatic lpmd_pkg::len_type pick_length();
      case ($urandom_range(0, 15))
         0: return part_limit + 1'b1;
         1: return lpmd_pkg::len_type'($urandom);
         2, 3: return '0;
         default: return lpmd_pkg::len_type'($urandom_range(0, part_limit));
      endcase
   endfunction

   task automatic test_reset_limit();
      send_message(8'hFF, '0, '0, 0);
      send_message(8'h00, 32'h0010_0001, 32'hFFFF_FFFF, 0);
      send_header(8'h5A, 32'd1, 32'd1);
      send_byte(8'h00);
      send_byte(8'hFF);
   endtask

   task automatic test_limit_edges();
      write_part_limit('0);
      send_message(8'h11, '0, '0, 0);
      send_message(8'h12, 32'd1, '0, 0);
      send_message(8'h13, '0, 32'd1, 0);
      write_part_limit(32'd5);
      send_message(8'h21, 32'd5, '0, 0);
      send_message(8'h22, '0, 32'd6, 0);
      send_message(8'h23, 32'd5, 32'd5, 0);
      send_message(8'h24, 32'h8000_0005, 32'd5, 0);
      write_part_limit(lpmd_pkg::MAX_PART_RESET);
      send_message(8'h31, 32'd2, 32'd3, 0);
   endtask

   task automatic test_random_traffic();
      lpmd_pkg::len_type phase_limits[4];
      int                phase_end;
      int                pick;
      phase_limits = '{32'd2, 32'd48, lpmd_pkg::len_type'($urandom_range(4, 24)), 32'd12};
      foreach (phase_limits[p]) begin
         write_part_limit(phase_limits[p]);
         steady    = (p == 2);
         phase_end = sent_count + 400;
         while (sent_count < phase_end) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               repeat ($urandom_range(1, 12)) send_byte(8'($urandom));
            end else begin
               send_message(8'($urandom), pick_length(), pick_length(),
                            (pick == 1) ? $urandom_range(1, 8) : 0);
            end
         end
      end
      steady = 1'b0;
   endtask

   task automatic test_widest_lengths();
      write_part_limit(32'hFFFF_FFFF);
      send_message(8'h41, 32'd3, 32'd2, 0);
   endtask

   task automatic test_huge_body();
      send_message(8'h43, '0, '0, 0);
      send_header(8'h44, 32'd2, 32'hFFFF_FFFF);
      repeat (40) send_byte(8'($urandom));
   endtask

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.rx_byte   = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_limit();
      test_limit_edges();
      test_random_traffic();
      test_widest_lengths();
      test_huge_body();

      drain_requests();
      repeat (8) @(posedge clock);

      $display("sent %0d bytes, checked %0d responses: %0d messages closed, %0d bad headers",
               sent_count, resp_count, end_seen, err_seen);
      $display("limits covered 0, small values, reset value and 0xFFFFFFFF with idle and stalls");
      if (fail_count == 0 && pending_bytes.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("%0d mismatches, %0d responses missing", fail_count, pending_bytes.size());
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> length_prefixed_message_deframer_top.f
rtl/core/lpmd_pkg.sv
rtl/core/lpmd_req_if.sv
rtl/core/lpmd_rsp_if.sv
rtl/core/lpmd_in_stage.sv
rtl/core/lpmd_core.sv
rtl/core/lpmd_out_stage.sv
rtl/core/length_prefixed_message_deframer_top.sv
bench/length_prefixed_message_deframer_top_tb.sv
